>>> rtl/swc_pkg.sv
// ----------------------------------------------------------------------------
// swc_pkg: shared types and constants of the stopwatch/countdown controller
// Holds the time width, the one-hot mode type, the controller state record,
// the reciprocal used to split the shown time into minutes and seconds, and
// the field widths of the stream channels.
// ----------------------------------------------------------------------------
package swc_pkg;

	// Width of the elapsed time and the preset, in seconds.
	localparam int unsigned TIME_BITS = 16;
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	// Seconds per minute and the largest seconds value.
	localparam int unsigned SEC_PER_MIN = 60;
	localparam int unsigned SEC_MAX     = 59;

	// Output field widths.
	localparam int unsigned MODE_CODE_W = 3;
	localparam int unsigned MIN_W       = 11;
	localparam int unsigned SEC_W       = 6;

	// Stream widths: tdata is padded to whole bytes.
	localparam int unsigned KEY_W        = 4;
	localparam int unsigned IN_TDATA_W   = 8;
	localparam int unsigned IN_TUSER_W   = 1;
	localparam int unsigned OUT_FIELDS_W = MODE_CODE_W + 1 + MIN_W + SEC_W + 1;
	localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Request kinds carried in tuser.
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_KEY  = 1'b1;

	// Key bit positions, lowest has priority.
	localparam int unsigned KEY_MODE  = 0;
	localparam int unsigned KEY_SET   = 1;
	localparam int unsigned KEY_START = 2;
	localparam int unsigned KEY_OK    = 3;

	// Reported mode codes.
	localparam logic [MODE_CODE_W-1:0] CODE_STOPPED  = 3'd0;
	localparam logic [MODE_CODE_W-1:0] CODE_RUNNING  = 3'd1;
	localparam logic [MODE_CODE_W-1:0] CODE_PAUSED   = 3'd2;
	localparam logic [MODE_CODE_W-1:0] CODE_SETMIN   = 3'd3;
	localparam logic [MODE_CODE_W-1:0] CODE_SETSEC   = 3'd4;
	localparam logic [MODE_CODE_W-1:0] CODE_FINISHED = 3'd5;

	// Exact floor(x / 60) for x < 2**TIME_BITS: (x * RECIP) >> RECIP_SHIFT.
	localparam int unsigned RECIP_SHIFT = TIME_BITS + 6;
	localparam int unsigned RECIP_W     = RECIP_SHIFT - 5;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SEC_MAX)) / 64'(SEC_PER_MIN));
	localparam int unsigned PROD_W = TIME_BITS + RECIP_W;

	// Controller modes, one-hot.
	typedef enum logic [5:0] {
		MODE_STOPPED  = 6'b000001,
		MODE_RUNNING  = 6'b000010,
		MODE_PAUSED   = 6'b000100,
		MODE_SETMIN   = 6'b001000,
		MODE_SETSEC   = 6'b010000,
		MODE_FINISHED = 6'b100000
	} mode_t;

	// Architectural state of the controller.
	typedef struct packed {
		mode_t                mode;
		logic                 down;
		logic [TIME_BITS-1:0] elapsed;
		logic [TIME_BITS-1:0] preset;
		logic                 blink;
	} state_t;

	// One result item.
	typedef struct packed {
		logic                   inverted;
		logic [SEC_W-1:0]       shown_seconds;
		logic [MIN_W-1:0]       shown_minutes;
		logic                   counting_down;
		logic [MODE_CODE_W-1:0] mode_code;
	} result_t;

	// Reported code of a mode.
	function automatic logic [MODE_CODE_W-1:0] mode_code(input mode_t m);
		logic [MODE_CODE_W-1:0] c;
		case (m)
			MODE_STOPPED:  c = CODE_STOPPED;
			MODE_RUNNING:  c = CODE_RUNNING;
			MODE_PAUSED:   c = CODE_PAUSED;
			MODE_SETMIN:   c = CODE_SETMIN;
			MODE_SETSEC:   c = CODE_SETSEC;
			MODE_FINISHED: c = CODE_FINISHED;
			default:       c = CODE_STOPPED;
		endcase
		return c;
	endfunction

endpackage

>>> rtl/swc_core.sv
// ----------------------------------------------------------------------------
// swc_core: input register and mode/time state update
// Registers each accepted request, then applies it to the controller state
// once the previous state has been taken or none is pending. A valid flag marks
// state that has not yet been handed to the result stage.
// ----------------------------------------------------------------------------
module swc_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [swc_pkg::IN_TDATA_W-1:0]    s_tdata,   // [3:0] key_bits
	input  logic [swc_pkg::IN_TUSER_W-1:0]    s_tuser,   // [0] req_type
	output swc_pkg::state_t                   st,
	output logic                              st_valid,
	input  logic                              st_take
);
	import swc_pkg::*;

	logic               v_s1;
	logic               req_s1;
	logic [KEY_W-1:0]   keys_s1;
	logic               upd_en;
	logic               in_en;
	state_t             st_q;
	state_t             st_nxt;
	logic               st_valid_q;
	logic [TIME_BITS:0] preset_plus_min;
	logic [TIME_BITS:0] preset_plus_sec;

	// Stage enables: the state may move when its last result is taken.
	assign upd_en   = v_s1 && (!st_valid_q || st_take);
	assign in_en    = !v_s1 || upd_en;
	assign s_tready = in_en;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_en && s_tvalid) begin
			req_s1  <= s_tuser[0];
			keys_s1 <= s_tdata[KEY_W-1:0];
		end
	end

	// Saturating preset increments.
	assign preset_plus_min = {1'b0, st_q.preset} + (TIME_BITS+1)'(SEC_PER_MIN);
	assign preset_plus_sec = {1'b0, st_q.preset} + (TIME_BITS+1)'(1);

	// Next state for the registered request.
	always_comb begin
		st_nxt = st_q;
		if (req_s1 == REQ_TICK) begin
			if (st_q.mode == MODE_RUNNING) begin
				if (st_q.down) begin
					if (st_q.elapsed == '0) begin
						st_nxt.mode = MODE_FINISHED;
					end else begin
						st_nxt.elapsed = st_q.elapsed - TIME_BITS'(1);
					end
				end else if (st_q.elapsed != TIME_MAX) begin
					st_nxt.elapsed = st_q.elapsed + TIME_BITS'(1);
				end
			end
			if (st_q.mode == MODE_SETMIN || st_q.mode == MODE_SETSEC) begin
				st_nxt.elapsed = st_q.preset;
			end
			if (st_nxt.mode == MODE_FINISHED) begin
				st_nxt.blink = ~st_q.blink;
			end
		end else if (keys_s1[KEY_MODE]) begin
			case (st_q.mode)
				MODE_STOPPED: st_nxt.down = ~st_q.down;
				MODE_SETMIN: begin
					st_nxt.preset = preset_plus_min[TIME_BITS] ? TIME_MAX
						: preset_plus_min[TIME_BITS-1:0];
				end
				MODE_SETSEC: begin
					st_nxt.preset = preset_plus_sec[TIME_BITS] ? TIME_MAX
						: preset_plus_sec[TIME_BITS-1:0];
				end
				MODE_FINISHED: begin
					st_nxt.blink   = 1'b0;
					st_nxt.mode    = MODE_STOPPED;
					st_nxt.elapsed = '0;
				end
				default: st_nxt = st_q;
			endcase
		end else if (keys_s1[KEY_SET]) begin
			case (st_q.mode)
				MODE_STOPPED: st_nxt.mode = MODE_SETMIN;
				MODE_RUNNING: st_nxt.mode = MODE_PAUSED;
				MODE_PAUSED:  st_nxt.mode = MODE_RUNNING;
				MODE_SETMIN: begin
					if (st_q.preset > TIME_BITS'(SEC_MAX)) begin
						st_nxt.preset = st_q.preset - TIME_BITS'(SEC_PER_MIN);
					end
				end
				MODE_SETSEC: begin
					if (st_q.preset != '0) begin
						st_nxt.preset = st_q.preset - TIME_BITS'(1);
					end
				end
				MODE_FINISHED: begin
					st_nxt.blink   = 1'b0;
					st_nxt.elapsed = st_q.down ? st_q.preset : '0;
					st_nxt.mode    = MODE_RUNNING;
				end
				default: st_nxt = st_q;
			endcase
		end else if (keys_s1[KEY_START]) begin
			case (st_q.mode)
				MODE_STOPPED: begin
					st_nxt.mode = MODE_RUNNING;
					if (st_q.down) begin
						st_nxt.elapsed = st_q.preset;
					end
				end
				MODE_RUNNING: st_nxt.mode = MODE_FINISHED;
				MODE_PAUSED:  st_nxt.mode = MODE_FINISHED;
				MODE_SETMIN:  st_nxt.mode = MODE_SETSEC;
				MODE_SETSEC:  st_nxt.mode = MODE_SETMIN;
				default:      st_nxt = st_q;
			endcase
		end else if (keys_s1[KEY_OK]) begin
			if (st_q.mode == MODE_SETMIN || st_q.mode == MODE_SETSEC) begin
				st_nxt.mode = MODE_STOPPED;
			end
		end
	end

	// Controller state and its pending flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode    <= MODE_STOPPED;
			st_q.down    <= 1'b0;
			st_q.elapsed <= '0;
			st_q.preset  <= '0;
			st_q.blink   <= 1'b0;
			st_valid_q   <= 1'b0;
		end else begin
			if (upd_en) begin
				st_q <= st_nxt;
			end
			if (upd_en) begin
				st_valid_q <= 1'b1;
			end else if (st_take) begin
				st_valid_q <= 1'b0;
			end
		end
	end

	assign st       = st_q;
	assign st_valid = st_valid_q;

endmodule

>>> rtl/swc_fmt.sv
// ----------------------------------------------------------------------------
// swc_fmt: result stage
// Selects the shown time, splits it into minutes and seconds with a
// reciprocal multiply, and holds the result item in the output register.
// ----------------------------------------------------------------------------
module swc_fmt (
	input  logic            clk,
	input  logic            arst_n,
	input  swc_pkg::state_t st,
	input  logic            st_valid,
	output logic            st_take,
	output logic            res_valid,
	input  logic            res_ready,
	output swc_pkg::result_t res
);
	import swc_pkg::*;

	logic [TIME_BITS-1:0] shown;
	logic [PROD_W-1:0]    prod;
	logic [TIME_BITS-1:0] quot;
	logic [TIME_BITS-1:0] quot_x60;
	logic [TIME_BITS-1:0] rem;
	logic                 res_valid_q;
	result_t              res_q;

	// The set modes show the preset, the others the elapsed time.
	assign shown = (st.mode == MODE_SETMIN || st.mode == MODE_SETSEC) ?
		st.preset : st.elapsed;

	// Exact division by sixty: reciprocal multiply, remainder by shift-subtract.
	assign prod     = PROD_W'(shown) * PROD_W'(RECIP);
	assign quot     = TIME_BITS'(prod >> RECIP_SHIFT);
	assign quot_x60 = (quot << 6) - (quot << 2);
	assign rem      = shown - quot_x60;

	// Output register takes new state when empty or being drained.
	assign st_take = st_valid && (!res_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || res_ready) begin
			res_valid_q <= st_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (st_take) begin
			res_q.mode_code     <= mode_code(st.mode);
			res_q.counting_down <= st.down;
			res_q.shown_minutes <= quot[MIN_W-1:0];
			res_q.shown_seconds <= rem[SEC_W-1:0];
			res_q.inverted      <= st.blink;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> rtl/stopwatch_countdown_controller.sv
// ----------------------------------------------------------------------------
// stopwatch_countdown_controller: four-key stopwatch and countdown timer
// Requests arrive on the s_ stream: tuser selects a one-second tick or a key
// event, tdata carries the pressed keys (lowest set bit wins). Every request
// yields exactly one result transfer on the m_ stream with the mode code,
// the count direction, the shown time as minutes and seconds, and the blink
// flag.
// Order: an accepted request is held in the input register, applied to the
// state register, and its result is then loaded into the result register.
// Throughput: one request per cycle while m_tready is high; the three
// registered stages (input, state, result) each hold one item.
// Reset: the timer is stopped, counts up, time, preset and blink are zero,
// and both streams are empty.
// Stalls: when the receiver holds m_tready low, the result register holds
// its transfer, the state and input stages fill behind it, and s_tready
// drops once all three stages are full.
// ----------------------------------------------------------------------------
module stopwatch_countdown_controller (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [swc_pkg::IN_TDATA_W-1:0]   s_tdata,  // [3:0] key_bits, rest zero
	input  logic [swc_pkg::IN_TUSER_W-1:0]   s_tuser,  // [0] req_type
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [2:0] mode_code, [3] counting_down, [14:4] shown_minutes,
	// [20:15] shown_seconds, [21] inverted, rest zero
	output logic [swc_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import swc_pkg::*;

	state_t  st;
	logic    st_valid;
	logic    st_take;
	result_t res;

	// Request register and state update.
	swc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.st       (st),
		.st_valid (st_valid),
		.st_take  (st_take)
	);

	// Shown time split and result register.
	swc_fmt u_fmt (
		.clk       (clk),
		.arst_n    (arst_n),
		.st        (st),
		.st_valid  (st_valid),
		.st_take   (st_take),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// Pack the result fields, lowest field first, padded with zeros.
	assign m_tdata = OUT_TDATA_W'(res);

endmodule

>>> tb/swc_checker.sv
// ----------------------------------------------------------------------------
// swc_checker: result checker of the stopwatch/countdown controller
// Watches both stream channels. Every accepted request is run through a
// local model of the timer, and the status it predicts is queued. Every
// accepted result is compared field by field with the oldest queued status.
// The number of mismatches and of results still awaited go to the top.
// ----------------------------------------------------------------------------
module swc_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [swc_pkg::IN_TDATA_W-1:0]  s_tdata,  // [3:0] key_bits, rest zero
	input  logic [swc_pkg::IN_TUSER_W-1:0]  s_tuser,  // [0] req_type
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// [2:0] mode_code, [3] counting_down, [14:4] shown_minutes,
	// [20:15] shown_seconds, [21] inverted, rest zero
	input  logic [swc_pkg::OUT_TDATA_W-1:0] m_tdata,
	output int                              fail_count,
	output int                              pending_results
);
	timeunit 1ns;
	timeprecision 1ps;
	import swc_pkg::*;

	// Timer state as the checker sees it. The mode is kept as its reported code.
	logic [MODE_CODE_W-1:0] cur_code;
	logic                   cur_down;
	logic [TIME_BITS-1:0]   cur_elapsed;
	logic [TIME_BITS-1:0]   cur_preset;
	logic                   cur_blink;

	// Statuses predicted for requests whose result has not arrived yet.
	result_t status_q[$];

	initial begin
		fail_count      = 0;
		pending_results = 0;
	end

	// Prints one line for a mismatch and counts it.
	task automatic report_mismatch(input string what);
		$display("[%0t ns] checker: %s", $time, what);
		fail_count++;
	endtask

	// Adds to a time and holds it at the largest value the width allows.
	function automatic logic [TIME_BITS-1:0] sat_plus(input logic [TIME_BITS-1:0] t,
			input int unsigned inc);
		logic [TIME_BITS:0] sum;
		sum = {1'b0, t} + (TIME_BITS+1)'(inc);
		return (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_BITS-1:0];
	endfunction

	// One-second tick: count, copy the preset in the set modes, blink when done.
	function automatic void apply_tick();
		if (cur_code == CODE_RUNNING) begin
			if (cur_down) begin
				if (cur_elapsed == '0)
					cur_code = CODE_FINISHED;
				else
					cur_elapsed = cur_elapsed - 1'b1;
			end else begin
				cur_elapsed = sat_plus(cur_elapsed, 1);
			end
		end
		if (cur_code == CODE_SETMIN || cur_code == CODE_SETSEC)
			cur_elapsed = cur_preset;
		if (cur_code == CODE_FINISHED)
			cur_blink = ~cur_blink;
	endfunction

	// Key event: only the lowest pressed key acts, and only where it has a meaning.
	function automatic void apply_keys(input logic [KEY_W-1:0] keys);
		if (keys[KEY_MODE]) begin
			case (cur_code)
				CODE_STOPPED:  cur_down = ~cur_down;
				CODE_SETMIN:   cur_preset = sat_plus(cur_preset, SEC_PER_MIN);
				CODE_SETSEC:   cur_preset = sat_plus(cur_preset, 1);
				CODE_FINISHED: begin
					cur_blink   = 1'b0;
					cur_code    = CODE_STOPPED;
					cur_elapsed = '0;
				end
				default: ;
			endcase
		end else if (keys[KEY_SET]) begin
			case (cur_code)
				CODE_STOPPED: cur_code = CODE_SETMIN;
				CODE_RUNNING: cur_code = CODE_PAUSED;
				CODE_PAUSED:  cur_code = CODE_RUNNING;
				CODE_SETMIN: begin
					if (cur_preset > SEC_MAX)
						cur_preset = cur_preset - TIME_BITS'(SEC_PER_MIN);
				end
				CODE_SETSEC: begin
					if (cur_preset != '0)
						cur_preset = cur_preset - 1'b1;
				end
				CODE_FINISHED: begin
					cur_blink   = 1'b0;
					cur_elapsed = cur_down ? cur_preset : '0;
					cur_code    = CODE_RUNNING;
				end
				default: ;
			endcase
		end else if (keys[KEY_START]) begin
			case (cur_code)
				CODE_STOPPED: begin
					cur_code = CODE_RUNNING;
					if (cur_down)
						cur_elapsed = cur_preset;
				end
				CODE_RUNNING, CODE_PAUSED: cur_code = CODE_FINISHED;
				CODE_SETMIN: cur_code = CODE_SETSEC;
				CODE_SETSEC: cur_code = CODE_SETMIN;
				default: ;
			endcase
		end else if (keys[KEY_OK]) begin
			if (cur_code == CODE_SETMIN || cur_code == CODE_SETSEC)
				cur_code = CODE_STOPPED;
		end
	endfunction

	// Applies one request and returns the status the controller should report.
	function automatic result_t advance_timer(input logic req,
			input logic [KEY_W-1:0] keys);
		result_t              st;
		logic [TIME_BITS-1:0] shown;
		if (req == REQ_TICK)
			apply_tick();
		else
			apply_keys(keys);
		shown = (cur_code == CODE_SETMIN || cur_code == CODE_SETSEC) ?
			cur_preset : cur_elapsed;
		st.mode_code     = cur_code;
		st.counting_down = cur_down;
		st.shown_minutes = MIN_W'(shown / SEC_PER_MIN);
		st.shown_seconds = SEC_W'(shown % SEC_PER_MIN);
		st.inverted      = cur_blink;
		return st;
	endfunction

	// Results are checked before the request of the same edge is queued, since
	// no result can leave in the cycle its request arrives.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			cur_code    = CODE_STOPPED;
			cur_down    = 1'b0;
			cur_elapsed = '0;
			cur_preset  = '0;
			cur_blink   = 1'b0;
			status_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[OUT_FIELDS_W-1:0];
				if (status_q.size() == 0) begin
					report_mismatch($sformatf("result 0x%0h with none awaited", m_tdata));
				end else begin
					want = status_q.pop_front();
					if (got.mode_code !== want.mode_code)
						report_mismatch($sformatf("mode_code %0d, expected %0d",
							got.mode_code, want.mode_code));
					if (got.counting_down !== want.counting_down)
						report_mismatch($sformatf("counting_down %0d, expected %0d",
							got.counting_down, want.counting_down));
					if (got.shown_minutes !== want.shown_minutes)
						report_mismatch($sformatf("shown_minutes %0d, expected %0d",
							got.shown_minutes, want.shown_minutes));
					if (got.shown_seconds !== want.shown_seconds)
						report_mismatch($sformatf("shown_seconds %0d, expected %0d",
							got.shown_seconds, want.shown_seconds));
					if (got.inverted !== want.inverted)
						report_mismatch($sformatf("inverted %0d, expected %0d",
							got.inverted, want.inverted));
					if (m_tdata[OUT_TDATA_W-1:OUT_FIELDS_W] !== '0)
						report_mismatch($sformatf("tdata padding 0x%0h, expected zero",
							m_tdata[OUT_TDATA_W-1:OUT_FIELDS_W]));
				end
			end
			if (s_tvalid && s_tready)
				status_q.push_back(advance_timer(s_tuser[0], s_tdata[KEY_W-1:0]));
		end
		pending_results <= status_q.size();
	end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the stopwatch/countdown controller
// Drives tick and key requests: a short directed walk through every mode and
// corner, a preset pushed to its limit and a count up from the largest time,
// random timer sessions mixed with random requests. Both sides idle at
// random; the receiver also holds off long enough to stall the input. A
// separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import swc_pkg::*;

	localparam int RANDOM_ITEMS   = 700;
	localparam int RX_HOLD_CYCLES = 60;

	// Single keys by their bit positions.
	localparam logic [KEY_W-1:0] K_NONE  = '0;
	localparam logic [KEY_W-1:0] K_MODE  = KEY_W'(1 << KEY_MODE);
	localparam logic [KEY_W-1:0] K_SET   = KEY_W'(1 << KEY_SET);
	localparam logic [KEY_W-1:0] K_START = KEY_W'(1 << KEY_START);
	localparam logic [KEY_W-1:0] K_OK    = KEY_W'(1 << KEY_OK);

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // [3:0] key_bits, rest zero
	logic [IN_TUSER_W-1:0]  s_tuser;   // [0] req_type
	logic                   m_tvalid;
	logic                   m_tready;
	// [2:0] mode_code, [3] counting_down, [14:4] shown_minutes,
	// [20:15] shown_seconds, [21] inverted, rest zero
	logic [OUT_TDATA_W-1:0] m_tdata;

	int fail_count;
	int pending_results;
	int n_sent = 0;
	int random_end;

	// Idling controls shared between the stimulus and the receiver.
	bit tx_steady   = 1'b0;
	bit rx_steady   = 1'b0;
	bit rx_hold_req = 1'b0;
	bit rx_hold_ack = 1'b0;

	stopwatch_countdown_controller u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	swc_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	// Clock with a 4 ns period.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	// Receiver: random hold-offs, or one long hold-off when the stimulus asks.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req != rx_hold_ack) begin
				rx_hold_ack = rx_hold_req;
				m_tready    = 1'b0;
				repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				m_tready = rx_steady || ($urandom_range(99) >= 15);
			end
		end
	end

	// Offers one request, maybe after a random gap, and waits for its transfer.
	task automatic send_item(input logic req, input logic [KEY_W-1:0] keys);
		if (!tx_steady && $urandom_range(99) < 15) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = req;
		s_tdata  = {{(IN_TDATA_W-KEY_W){1'b0}}, keys};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		n_sent++;
	endtask

	// Tick requests carry random key bits, which must not matter.
	task automatic tick();
		send_item(REQ_TICK, KEY_W'($urandom_range(15)));
	endtask

	task automatic press(input logic [KEY_W-1:0] keys);
		send_item(REQ_KEY, keys);
	endtask

	task automatic noise_item();
		send_item(1'($urandom_range(1)), KEY_W'($urandom_range(15)));
	endtask

	// Stops offering until every result has come back.
	task automatic drain();
		s_tvalid = 1'b0;
		wait (pending_results == 0);
		@(negedge clk);
	endtask

	// Brings the timer to stopped from any mode: ok leaves the set modes,
	// start twice ends up in finished, and mode leaves finished.
	task automatic go_home();
		press(K_OK);
		press(K_START);
		press(K_START);
		press(K_MODE);
	endtask

	// One timer session: set a preset, run, maybe stop, blink, then leave.
	task automatic timer_session();
		int r;
		go_home();
		if ($urandom_range(1))
			press(K_MODE);
		press(K_SET);
		repeat ($urandom_range(2))
			press(($urandom_range(99) < 35) ? K_MODE : K_SET);
		if ($urandom_range(3) == 0)
			tick();
		press(K_START);
		repeat ($urandom_range(8)) begin
			r = $urandom_range(99);
			if (r < 55)
				press(K_MODE);
			else if (r < 85)
				press(K_SET);
			else
				tick();
		end
		press(K_OK);
		press(K_START);
		repeat ($urandom_range(40)) begin
			r = $urandom_range(99);
			if (r < 85)
				tick();
			else if (r < 93)
				press(K_SET);
			else
				noise_item();
		end
		if ($urandom_range(1))
			press(K_START);
		repeat ($urandom_range(4)) tick();
		press($urandom_range(1) ? K_SET : K_MODE);
	endtask

	// Main stimulus.
	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = REQ_TICK;
		s_tdata  = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed walk: idle tick, no key, ignored key, preset limits,
		// lowest key wins, countdown to finished with blinking, restart, pause.
		// It ends stopped and counting down.
		tick();
		press(K_NONE);
		press(K_OK);
		press(K_SET);
		press(K_MODE);
		tick();
		press(K_SET);
		press(K_SET);
		press(K_START);
		press(K_SET);
		press(K_MODE);
		press(K_MODE);
		press(4'b1111);
		press(K_START);
		press(K_OK);
		press(K_MODE);
		press(K_START);
		repeat (5) tick();
		press(K_SET);
		press(K_SET);
		press(K_SET);
		press(K_START);
		press(K_MODE);
		drain();

		// Switch to count up and push the preset past its limit in minute
		// steps without idling on either side.
		press(K_MODE);
		press(K_SET);
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		repeat (32'(TIME_MAX) / SEC_PER_MIN + 2) press(K_MODE);
		tx_steady = 1'b0;
		rx_steady = 1'b0;

		// Second and minute steps at the limit, with the preset copied in.
		tick();
		press(K_START);
		press(K_MODE);
		press(K_SET);
		press(K_MODE);
		tick();
		press(K_START);
		press(K_SET);
		press(K_MODE);
		tick();

		// Count up from the largest time: the elapsed time holds there.
		press(K_OK);
		press(K_START);
		repeat (4) tick();
		press(K_START);
		press(K_MODE);
		drain();

		// Long receiver hold-off while requests keep coming.
		tx_steady   = 1'b1;
		rx_hold_req = ~rx_hold_req;
		repeat (20) noise_item();
		tx_steady = 1'b0;
		drain();

		// Random sessions mixed with bursts of random requests.
		random_end = n_sent + RANDOM_ITEMS;
		while (n_sent < random_end) begin
			if ($urandom_range(99) < 70) begin
				timer_session();
			end else begin
				repeat ($urandom_range(8, 1)) noise_item();
			end
		end

		// Wait for the last results, then report the outcome.
		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> files.f
rtl/swc_pkg.sv
rtl/swc_core.sv
rtl/swc_fmt.sv
rtl/stopwatch_countdown_controller.sv
tb/swc_checker.sv
tb/tb.sv
